@@ hw/rtl/jcd_pkg.sv @@
// Shared types and constants for the Japanese charset detector.
package jcd_pkg;

  localparam int unsigned ScanLimit = 131072;
  localparam int CntW = 18;
  localparam logic [CntW-1:0] SCAN_LIMIT = CntW'(ScanLimit);
  localparam logic [CntW-1:0] COUNT_SAT = {CntW{1'b1}};
  localparam logic [7:0] MARGIN_RESET = 8'd32;
  localparam int QDepth = 4;
  localparam int QPtrW = 2;

  localparam logic [3:0] CS_SJIS = 4'd0;
  localparam logic [3:0] CS_EUC = 4'd1;
  localparam logic [3:0] CS_ISO2022JP = 4'd2;
  localparam logic [3:0] CS_UTF8_BOM = 4'd3;
  localparam logic [3:0] CS_UTF8 = 4'd4;
  localparam logic [3:0] CS_U16LE_BOM = 4'd5;
  localparam logic [3:0] CS_U16BE_BOM = 4'd6;
  localparam logic [3:0] CS_U16LE = 4'd7;
  localparam logic [3:0] CS_U16BE = 4'd8;

  localparam logic [1:0] LB_CR = 2'd0;
  localparam logic [1:0] LB_LF = 2'd1;
  localparam logic [1:0] LB_CRLF = 2'd2;

  localparam logic [1:0] WIDE_NONE = 2'd0;
  localparam logic [1:0] WIDE_LE = 2'd1;
  localparam logic [1:0] WIDE_BE = 2'd2;

  localparam logic [1:0] SV_NONE = 2'd0;
  localparam logic [1:0] SV_EUC = 2'd1;
  localparam logic [1:0] SV_SJIS = 2'd2;

  // queue entry: one byte, its last-byte flag, its file position and its in-scan tag
  typedef struct packed {
    logic [7:0] data;
    logic last;
    logic in_scan;
    logic [CntW-1:0] pos;
  } q_entry_t;

endpackage

@@ hw/rtl/japanese_charset_detector_top.sv @@
// Top level of the Japanese charset detector.
// Takes one file byte per cycle on the s_ stream (tlast on the final byte) and
// returns one result per file on the m_ stream: charset_code in tdata[3:0],
// line_break in tdata[5:4]. The scan engine handles one byte per cycle; each
// file end adds extra engine steps (four zero-lookahead positions and one to
// register the result). A four-entry queue in front of the engine lets
// bytes keep arriving during those steps until it fills, then s_tready drops.
// The result step waits while an earlier result is still held by m_tready low.
// Only the first 131072 bytes are scanned. The user must write score_margin
// through cfg_we/cfg_data only while the block is idle; the block itself does
// not enforce this.
module japanese_charset_detector_top import jcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [7:0] cfg_data,  // score_margin
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,   // data_byte[7:0]
  input  logic s_tlast,         // last_byte
  output logic m_tvalid,
  input  logic m_tready,
  output logic [7:0] m_tdata    // charset_code[3:0], line_break[5:4], zero[7:6]
);

  q_entry_t q_wdata, q_rdata;
  logic q_push, q_full, q_pop, q_valid;

  jcd_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .q_full, .q_push, .q_wdata
  );

  jcd_queue u_queue (
    .clk, .rst, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .valid(q_valid), .rdata(q_rdata)
  );

  jcd_back u_back (
    .clk, .rst, .cfg_we, .cfg_data, .q_valid, .q_rdata, .q_pop,
    .m_tvalid, .m_tready, .m_tdata
  );

endmodule

@@ hw/rtl/jcd_front.sv @@
// Front end: accepts bytes, tracks file position and tags scan positions.
module jcd_front import jcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata, // data_byte
  input  logic s_tlast,       // last_byte
  input  logic q_full,
  output logic q_push,
  output q_entry_t q_wdata
);

  logic [CntW-1:0] pos;
  logic [CntW-1:0] pos_next;

  assign s_tready = !q_full;
  assign q_push = s_tvalid && s_tready;

  always_comb begin
    q_wdata.data = s_tdata;
    q_wdata.last = s_tlast;
    q_wdata.pos = pos;
    q_wdata.in_scan = (pos >= CntW'(4)) && ((pos - CntW'(4)) < SCAN_LIMIT);
    if (s_tlast) begin
      pos_next = '0;
    end else if (pos != COUNT_SAT) begin
      pos_next = pos + CntW'(1);
    end else begin
      pos_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (q_push) begin
      pos <= pos_next;
    end
  end

endmodule

@@ hw/rtl/jcd_queue.sv @@
// Four-entry queue between the front end and the scan engine.
module jcd_queue import jcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  q_entry_t wdata,
  output logic full,
  input  logic pop,
  output logic valid,
  output q_entry_t rdata
);

  q_entry_t mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0] count;

  assign full = count == (QPtrW+1)'(QDepth);
  assign valid = count != '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPtrW'(1);
      if (pop) rd_ptr <= rd_ptr + QPtrW'(1);
      case ({push, pop})
        2'b10: count <= count + (QPtrW+1)'(1);
        2'b01: count <= count - (QPtrW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/jcd_back.sv @@
// Scan engine: window checks, scores, end-of-file flush and result register.
module jcd_back import jcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [7:0] cfg_data,
  input  logic q_valid,
  input  q_entry_t q_rdata,
  output logic q_pop,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [7:0] m_tdata // charset_code[3:0], line_break[5:4], zero pad
);

  logic [7:0] win [5];
  logic [7:0] win_next [5];
  logic [23:0] head;
  logic [1:0] wmk;
  logic [CntW-1:0] nlead;
  logic ufail;
  logic signed [9:0] sdiff;
  logic [1:0] sverd;
  logic esc;
  logic [1:0] bverd;
  logic [2:0] fc;
  logic [CntW-1:0] n;
  logic [7:0] margin;
  logic [3:0] out_code;
  logic [1:0] out_lb;
  logic out_valid_q;

  logic step, fin, do_scan;
  logic [CntW:0] kf, j, u;
  logic [7:0] nb;
  logic [1:0] wmk_next, sverd_next, bverd_next;
  logic [CntW-1:0] nlead_next;
  logic ufail_next, esc_next;
  logic signed [9:0] sdiff_next;
  logic [2:0] ulen;
  logic sj, eu, cr0, lf0, lf1;
  logic signed [10:0] d;
  logic [3:0] code;

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  assign q_pop = (fc == 3'd0) && q_valid;
  assign step = q_pop || (fc >= 3'd1 && fc <= 3'd4);
  assign fin = (fc == 3'd5) && (!m_tvalid || m_tready);
  assign m_tvalid = out_valid_q;
  assign m_tdata = {2'b00, out_lb, out_code};

  always_comb begin
    nb = (fc == 3'd0) ? q_rdata.data : 8'h00;
    for (int i = 0; i < 4; i++) win_next[i] = win[i+1];
    win_next[4] = nb;

    kf = {1'b0, n} + (CntW+1)'(fc - 3'd1);
    if (fc == 3'd0) begin
      u = {1'b0, SCAN_LIMIT};
      j = {1'b0, q_rdata.pos} - (CntW+1)'(4);
      do_scan = q_pop && q_rdata.in_scan;
    end else begin
      u = (n < SCAN_LIMIT) ? {1'b0, n} : {1'b0, SCAN_LIMIT};
      j = kf - (CntW+1)'(4);
      do_scan = step && (kf >= (CntW+1)'(4)) && (j < u);
    end

    bverd_next = bverd;
    wmk_next = wmk;
    nlead_next = nlead;
    ufail_next = ufail;
    esc_next = esc;
    sdiff_next = sdiff;
    sverd_next = sverd;
    ulen = 3'd0;
    sj = 1'b0;
    eu = 1'b0;
    d = '0;
    // word = w0 | w1<<8
    lf0 = (win_next[0] == 8'h0A && win_next[1] == 8'h00) ||
          (win_next[0] == 8'h00 && win_next[1] == 8'h0A);
    cr0 = (win_next[0] == 8'h0D && win_next[1] == 8'h00) ||
          (win_next[0] == 8'h00 && win_next[1] == 8'h0D);
    lf1 = (win_next[2] == 8'h0A && win_next[3] == 8'h00) ||
          (win_next[2] == 8'h00 && win_next[3] == 8'h0A);

    if (do_scan) begin
      if (bverd == 2'd0) begin
        if (!j[0] && (j + (CntW+1)'(1) < u) && lf0) begin
          bverd_next = 2'd2;
        end else if (!j[0] && (j + (CntW+1)'(1) < u) && cr0) begin
          bverd_next = lf1 ? 2'd3 : 2'd1;
        end else if (win_next[0] == 8'h0D) begin
          bverd_next = (win_next[1] == 8'h0A) ? 2'd3 : 2'd1;
        end else if (win_next[0] == 8'h0A) begin
          bverd_next = 2'd2;
        end
      end

      if (wmk == WIDE_NONE && !j[0] && ((j >> 1) + (CntW+1)'(1) < (u >> 1))) begin
        if (win_next[1] == 8'h00 && (win_next[0] == 8'h0A || win_next[0] == 8'h0D)) begin
          wmk_next = WIDE_LE;
        end else if (win_next[0] == 8'h00 &&
                     (win_next[1] == 8'h0A || win_next[1] == 8'h0D)) begin
          wmk_next = WIDE_BE;
        end
      end

      if (!ufail && j == {1'b0, nlead} && (j + (CntW+1)'(4) < u)) begin
        if (!win_next[0][7]) ulen = 3'd1;
        else if (win_next[0][7:5] == 3'b110 && is_cont(win_next[1])) ulen = 3'd2;
        else if (win_next[0][7:4] == 4'b1110 && is_cont(win_next[1]) &&
                 is_cont(win_next[2])) ulen = 3'd3;
        else if (win_next[0][7:3] == 5'b11110 && is_cont(win_next[1]) &&
                 is_cont(win_next[2]) && is_cont(win_next[3])) ulen = 3'd4;
        if (ulen != 3'd0) nlead_next = nlead + CntW'(ulen);
        else ufail_next = 1'b1;
      end

      if (!esc && (j + (CntW+1)'(3) < u)) begin
        if (win_next[0] == 8'h1B) begin
          if ((win_next[1] == "$" && (win_next[2] == "B" || win_next[2] == "@")) ||
              (win_next[1] == "(" && (win_next[2] == "J" || win_next[2] == "B")))
            esc_next = 1'b1;
        end else if (sverd == SV_NONE) begin
          sj = (win_next[0] >= 8'hA0 && win_next[0] <= 8'hDF) ||
               (((win_next[0] >= 8'h81 && win_next[0] <= 8'h9F) ||
                 (win_next[0] >= 8'hE0 && win_next[0] <= 8'hFC)) &&
                win_next[1] >= 8'h40 && win_next[1] <= 8'hFC && win_next[1] != 8'h7F);
          eu = (win_next[0] == 8'h8E && win_next[1] >= 8'hA0 && win_next[1] <= 8'hDF) ||
               (win_next[0] >= 8'hA1 && win_next[0] <= 8'hFE &&
                win_next[1] >= 8'hA1 && win_next[1] <= 8'hFE);
          d = 11'(sdiff) + (eu ? 11'sd1 : 11'sd0) - (sj ? 11'sd1 : 11'sd0);
          sdiff_next = d[9:0];
          if (d > $signed({3'b000, margin})) sverd_next = SV_EUC;
          else if (d < -$signed({3'b000, margin})) sverd_next = SV_SJIS;
        end
      end
    end

    if (n > CntW'(4) && head[23:8] == 16'hFFFE) code = CS_U16LE_BOM;
    else if (n > CntW'(4) && head[23:8] == 16'hFEFF) code = CS_U16BE_BOM;
    else if (n > CntW'(4) && head == 24'hEFBBBF) code = CS_UTF8_BOM;
    else if (wmk == WIDE_LE) code = CS_U16LE;
    else if (wmk == WIDE_BE) code = CS_U16BE;
    else if (!ufail) code = esc ? CS_ISO2022JP : CS_UTF8;
    else if (sverd == SV_EUC) code = CS_EUC;
    else if (sverd == SV_SJIS) code = CS_SJIS;
    else if (esc) code = CS_ISO2022JP;
    else code = (sdiff > 10'sd0) ? CS_EUC : CS_SJIS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= MARGIN_RESET;
    end else if (cfg_we) begin
      margin <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_code <= code;
      out_lb <= (bverd != 2'd0) ? (bverd - 2'd1) : LB_CRLF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || fin) begin
      for (int i = 0; i < 5; i++) win[i] <= 8'h00;
      head <= '0;
      wmk <= WIDE_NONE;
      nlead <= '0;
      ufail <= 1'b0;
      sdiff <= '0;
      sverd <= SV_NONE;
      esc <= 1'b0;
      bverd <= 2'd0;
      fc <= 3'd0;
      n <= '0;
    end else if (step) begin
      win <= win_next;
      wmk <= wmk_next;
      nlead <= nlead_next;
      ufail <= ufail_next;
      sdiff <= sdiff_next;
      sverd <= sverd_next;
      esc <= esc_next;
      bverd <= bverd_next;
      if (fc == 3'd0) begin
        case (q_rdata.pos)
          CntW'(0): head[23:16] <= q_rdata.data;
          CntW'(1): head[15:8] <= q_rdata.data;
          CntW'(2): head[7:0] <= q_rdata.data;
          default: head <= head;
        endcase
        if (q_rdata.last) begin
          fc <= 3'd1;
          n <= (q_rdata.pos == COUNT_SAT) ? COUNT_SAT : q_rdata.pos + CntW'(1);
        end
      end else begin
        fc <= fc + 3'd1;
      end
    end
  end

endmodule

@@ hw/rtl/jcd_checker.sv @@
// Port-level checker for the Japanese charset detector, bound to the top.
module jcd_checker (
  input logic clk,
  input logic rst,
  input logic m_tvalid,
  input logic m_tready,
  input logic [7:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= 4'd8 && m_tdata[5:4] != 2'd3 && m_tdata[7:6] == 2'd0)
    else $error("bad result encoding");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result after reset");

endmodule

bind japanese_charset_detector_top jcd_checker u_jcd_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata
);

@@ tb/japanese_charset_detector_checker.sv @@
`timescale 1ns / 1ps
// Checker for the charset detector: predicts each file's result and compares it.
module japanese_charset_detector_checker import jcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [7:0] cfg_data,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [7:0] s_tdata,
  input  logic s_tlast,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [7:0] m_tdata,
  output int err_count,
  output int pending_count,
  output int files_checked
);

  typedef struct packed {
    logic [3:0] charset;
    logic [1:0] brk;
  } verdict_t;

  verdict_t expected_q[$];

  logic [7:0] win[5];
  int unsigned nbytes;
  logic [23:0] head;
  logic [1:0] wide_kind;
  int unsigned utf8_lead;
  int unsigned utf8_fail;
  int score;
  logic [1:0] score_dec;
  bit esc;
  logic [1:0] brk_dec;
  logic [7:0] margin;
  localparam int unsigned NoFail = 32'h3FFFF;

  assign pending_count = expected_q.size();

  function automatic bit is_cont(logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  task automatic clear_file();
    for (int i = 0; i < 5; i++) win[i] = 8'h00;
    nbytes = 0; head = '0; wide_kind = WIDE_NONE;
    utf8_lead = 0; utf8_fail = NoFail;
    score = 0; score_dec = SV_NONE; esc = 0; brk_dec = 2'd0;
  endtask

  task automatic shift_in(logic [7:0] b);
    for (int i = 0; i < 4; i++) win[i] = win[i+1];
    win[4] = b;
  endtask

  task automatic scan_at(int unsigned j, int unsigned u);
    logic [15:0] word;
    logic [15:0] nxt;
    logic [1:0] v;
    int unsigned len;
    bit sj, eu;
    logic [7:0] b1, b2, b3;
    word = {win[1], win[0]};
    nxt = {win[3], win[2]};
    if (brk_dec == 0) begin
      v = 0;
      if (j % 2 == 0 && j + 1 < u) begin
        if (word == 16'h000A || word == 16'h0A00) v = 2;
        else if (word == 16'h000D || word == 16'h0D00)
          v = (nxt == 16'h000A || nxt == 16'h0A00) ? 3 : 1;
      end
      if (v == 0) begin
        if (win[0] == 8'h0D) v = (win[1] == 8'h0A) ? 3 : 1;
        else if (win[0] == 8'h0A) v = 2;
      end
      brk_dec = v;
    end
    if (wide_kind == WIDE_NONE && j % 2 == 0 && j / 2 + 1 < u / 2) begin
      if (word == 16'h000A || word == 16'h000D) wide_kind = WIDE_LE;
      else if (word == 16'h0A00 || word == 16'h0D00) wide_kind = WIDE_BE;
    end
    if (utf8_fail == NoFail && j == utf8_lead && j + 4 < u) begin
      len = 0;
      if (!win[0][7]) len = 1;
      else if (win[0][7:5] == 3'b110 && is_cont(win[1])) len = 2;
      else if (win[0][7:4] == 4'b1110 && is_cont(win[1]) && is_cont(win[2])) len = 3;
      else if (win[0][7:3] == 5'b11110 && is_cont(win[1]) && is_cont(win[2])
               && is_cont(win[3])) len = 4;
      if (len != 0) utf8_lead = (utf8_lead + len) & NoFail;
      else utf8_fail = j & NoFail;
    end
    if (!esc && j + 3 < u) begin
      b1 = win[0]; b2 = win[1]; b3 = win[2];
      if (b1 == 8'h1B) begin
        if ((b2 == "$" && (b3 == "B" || b3 == "@")) || (b2 == "(" && (b3 == "J" || b3 == "B")))
          esc = 1;
      end else if (score_dec == SV_NONE) begin
        sj = (b1 >= 8'hA0 && b1 <= 8'hDF) ||
             (((b1 >= 8'h81 && b1 <= 8'h9F) || (b1 >= 8'hE0 && b1 <= 8'hFC)) &&
              b2 >= 8'h40 && b2 <= 8'hFC && b2 != 8'h7F);
        eu = (b1 == 8'h8E && b2 >= 8'hA0 && b2 <= 8'hDF) ||
             (b1 >= 8'hA1 && b1 <= 8'hFE && b2 >= 8'hA1 && b2 <= 8'hFE);
        if (eu) score++;
        if (sj) score--;
        if (score > int'(margin)) score_dec = SV_EUC;
        else if (score < -int'(margin)) score_dec = SV_SJIS;
      end
    end
  endtask

  task automatic take_byte(logic [7:0] b, logic lst);
    int unsigned k, n, u;
    verdict_t r;
    k = nbytes;
    shift_in(b);
    if (k < 3) head = head | (24'(b) << (8 * (2 - k)));
    if (k >= 4 && k - 4 < ScanLimit) scan_at(k - 4, ScanLimit);
    if (nbytes < 32'h3FFFF) nbytes++;
    if (lst) begin
      n = nbytes;
      u = n < ScanLimit ? n : ScanLimit;
      for (int t = 0; t < 4; t++) begin
        k = n + t;
        shift_in(8'h00);
        if (k >= 4 && k - 4 < u) scan_at(k - 4, u);
      end
      if (n > 4 && head[23:8] == 16'hFFFE) r.charset = CS_U16LE_BOM;
      else if (n > 4 && head[23:8] == 16'hFEFF) r.charset = CS_U16BE_BOM;
      else if (n > 4 && head == 24'hEFBBBF) r.charset = CS_UTF8_BOM;
      else if (wide_kind == WIDE_LE) r.charset = CS_U16LE;
      else if (wide_kind == WIDE_BE) r.charset = CS_U16BE;
      else if (utf8_fail == NoFail) r.charset = esc ? CS_ISO2022JP : CS_UTF8;
      else if (score_dec == SV_EUC) r.charset = CS_EUC;
      else if (score_dec == SV_SJIS) r.charset = CS_SJIS;
      else if (esc) r.charset = CS_ISO2022JP;
      else r.charset = score > 0 ? CS_EUC : CS_SJIS;
      r.brk = brk_dec != 0 ? brk_dec - 2'd1 : LB_CRLF;
      expected_q.push_back(r);
      clear_file();
    end
  endtask

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(posedge clk) begin
    verdict_t e;
    if (rst) begin
      clear_file();
      margin <= MARGIN_RESET;
      err_count <= 0;
      files_checked <= 0;
    end else begin
      if (cfg_we) margin <= cfg_data;
      if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) report("unexpected result", m_tdata, 8'h00);
        else begin
          e = expected_q.pop_front();
          files_checked <= files_checked + 1;
          if (m_tdata[3:0] !== e.charset)
            report("charset_code", 8'(m_tdata[3:0]), 8'(e.charset));
          if (m_tdata[5:4] !== e.brk)
            report("line_break", 8'(m_tdata[5:4]), 8'(e.brk));
          if (m_tdata[7:6] !== 2'b00) report("pad bits", 8'(m_tdata[7:6]), 8'h00);
        end
      end
    end
  end

endmodule

@@ tb/japanese_charset_detector_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the charset detector: stimulus, backpressure and verdict.
module japanese_charset_detector_top_tb import jcd_pkg::*;;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [7:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [7:0] m_tdata;
  int err_count, pending_count, files_checked;
  int cycle_count = 0;
  int bytes_sent = 0;
  bit hold_sink = 0;
  bit stim_done = 0;

  always #4 clk = ~clk;

  japanese_charset_detector_top u_dut (.*);
  japanese_charset_detector_checker u_chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_sink) m_tready <= 0;
    else if ($urandom_range(0, 3) == 0) m_tready <= 0;
    else m_tready <= 1;
  end

  task automatic send_byte(logic [7:0] b, logic lst);
    s_tvalid <= 1; s_tdata <= b; s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if ($urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 2))
        @(negedge clk);
    end
  endtask

  task automatic send_file(logic [7:0] f[$]);
    for (int i = 0; i < f.size(); i++) send_byte(f[i], i == f.size() - 1);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_margin(logic [7:0] m);
    drain();
    cfg_we <= 1; cfg_data <= m;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [7:0] rand_byte(int kind);
    case (kind)
      0: return 8'($urandom_range(8'hA1, 8'hFE));
      1: return 8'($urandom_range(8'h81, 8'h9F));
      2: return 8'($urandom_range(8'h40, 8'hFC));
      3: return 8'($urandom_range(8'h20, 8'h7E));
      default: return 8'($urandom);
    endcase
  endfunction

  // random file of a chosen flavor
  task automatic random_file();
    logic [7:0] f[$];
    int len, flavor, i;
    len = $urandom_range(1, 14);
    flavor = $urandom_range(0, 8);
    i = 0;
    case (flavor)
      0: f = {8'hFF, 8'hFE};
      1: f = {8'hFE, 8'hFF};
      2: f = {8'hEF, 8'hBB, 8'hBF};
      3: f = {8'h1B, "$", ($urandom_range(0, 1) ? "B" : "@")};
      default: f = {};
    endcase
    while (f.size() < len) begin
      case (flavor)
        4: f.push_back(rand_byte(0));
        5: begin f.push_back(rand_byte(1)); f.push_back(rand_byte(2)); end
        6: begin f.push_back(8'hE3); f.push_back(8'($urandom_range(8'h80, 8'hBF)));
             f.push_back(8'($urandom_range(8'h80, 8'hBF))); end
        7: f.push_back($urandom_range(0, 1) ? 8'h00 : rand_byte(3));
        default: f.push_back($urandom_range(0, 5) == 0 ? 8'($urandom) : rand_byte(3));
      endcase
      if ($urandom_range(0, 7) == 0)
        f.push_back($urandom_range(0, 1) ? 8'h0D : 8'h0A);
    end
    send_file(f);
  endtask

  initial begin
    logic [7:0] f[$];
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed files
    send_file({8'h00});
    send_file({8'hFF, 8'hFE, 8'h41, 8'h00, 8'h0A, 8'h00});
    send_file({8'hFE, 8'hFF, 8'h00, 8'h41, 8'h00, 8'h0D});
    send_file({8'hEF, 8'hBB, 8'hBF, 8'h41, 8'h0D, 8'h0A});
    send_file({8'h41, 8'h00, 8'h0A, 8'h00, 8'h42, 8'h00, 8'h43, 8'h00});
    send_file({8'h00, 8'h41, 8'h00, 8'h0D, 8'h00, 8'h42, 8'h00, 8'h43});
    send_file({8'h1B, "(", "J", 8'h41, 8'h42, 8'h0A});
    send_file({8'hA4, 8'hA2, 8'hA4, 8'hA4, 8'h8E, 8'hB1, 8'h0D});
    send_file({8'h82, 8'hA0, 8'h82, 8'hA2, 8'hFC, 8'hFC, 8'h0A});
    send_file({8'hFF, 8'hFE});
    send_file({8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80});
    send_file({8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41, 8'h41, 8'h41, 8'h41});
    set_margin(8'd1);
    send_file({8'hA4, 8'hA2, 8'hA4, 8'hA2, 8'hA4, 8'hA2, 8'hFF});
    set_margin(8'd255);
    for (int i = 0; i < 600; i++) f.push_back(i % 2 ? 8'hA2 : 8'hA4);
    f.push_back(8'hFF);
    send_file(f);
    // hold the receiver off while files keep coming, enough to fill the queue
    drain();
    hold_sink = 1;
    fork
      repeat (6) send_file({8'h41, 8'h42});
      begin
        repeat (300) @(negedge clk);
        hold_sink = 0;
      end
    join
    set_margin(8'd0);
    while (bytes_sent < 740) begin
      if ($urandom_range(0, 40) == 0) set_margin(8'($urandom_range(0, 255)));
      random_file();
    end
    set_margin(8'd32);
    repeat (20) random_file();
    drain();
    stim_done = 1;
    $display("Covered %0d bytes, %0d files checked across margin settings 0..255",
             bytes_sent, files_checked);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
